[rtl/core/src_pkg.sv]
// Shared types, constants and state encodings for the rank correlation block.
`timescale 1ns / 1ps

package src_pkg;

  localparam int DEF_MAX_PAIRS  = 1024;
  localparam int DEF_VALUE_BITS = 32;

  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int MUL_W    = 64;
  localparam int PROD_W   = 128;
  localparam int ROOT_W   = 31;
  localparam int QUO_W    = 61;
  localparam int SQ_W     = 62;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_value;
    logic                      x_valid;
    logic signed [FIELD_W-1:0] y_value;
    logic                      y_valid;
    logic                      last_sample;
  } src_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] correlation;
    logic                      undefined;
    logic [COUNT_W-1:0]        pair_count;
  } src_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_PIVOT,
    ST_SCAN,
    ST_FLUSH,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DONE
  } src_state_t;

  typedef enum logic [2:0] {
    MOP_XY,
    MOP_XX,
    MOP_YY,
    MOP_P,
    MOP_S
  } src_mop_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT,
    RT_DONE
  } src_root_state_t;

endpackage

[rtl/core/src_mul.sv]
// Shared 64 x 64 unsigned multiplier built from one 32 x 32 unit that forms the partial products in turn.
`timescale 1ns / 1ps

module src_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [src_pkg::MUL_W-1:0]   a,
  input  logic [src_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [src_pkg::PROD_W-1:0]  prod
);

  logic [src_pkg::MUL_W-1:0]  a_r, b_r;
  logic [src_pkg::PROD_W-1:0] acc_r;
  logic [1:0]                 idx_r;
  logic                       run_r, done_r;
  logic [31:0]                a_part, b_part;
  logic [63:0]                part;
  logic [src_pkg::PROD_W-1:0] part_sh;

  always_comb begin
    a_part = idx_r[1] ? a_r[63:32] : a_r[31:0];
    b_part = idx_r[0] ? b_r[63:32] : b_r[31:0];
    part   = a_part * b_part;
    case (idx_r)
      2'd0:    part_sh = {64'b0, part};
      2'd3:    part_sh = {part, 64'b0};
      default: part_sh = {32'b0, part, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      done_r <= run_r && !start && (idx_r == 2'd3);
      if (start) begin
        run_r <= 1'b1;
        idx_r <= 2'd0;
      end else if (run_r) begin
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + part_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/core/src_root.sv]
// Bit-serial divider followed by a digit-by-digit square root for the final scaling.
`timescale 1ns / 1ps

module src_root (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [src_pkg::PROD_W-1:0]  num,
  input  logic [src_pkg::PROD_W-1:0]  den,
  output logic                        done,
  output logic [src_pkg::ROOT_W-1:0]  root
);

  src_pkg::src_root_state_t state_r, state_nxt;

  logic [src_pkg::PROD_W:0]   rem_r;
  logic [src_pkg::PROD_W-1:0] den_r;
  logic [src_pkg::QUO_W-1:0]  quo_r;
  logic [5:0]                 cnt_r;
  logic [src_pkg::SQ_W-1:0]   sq_num_r, res_r, bit_r;

  logic                       div_ge;
  logic [src_pkg::PROD_W:0]   div_diff;
  logic [src_pkg::QUO_W-1:0]  quo_nxt;
  logic [src_pkg::SQ_W-1:0]   sq_t;
  logic                       sq_ge;

  always_comb begin
    div_ge   = rem_r >= {1'b0, den_r};
    div_diff = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;
    quo_nxt  = {quo_r[src_pkg::QUO_W-2:0], div_ge};
    sq_t     = res_r + bit_r;
    sq_ge    = sq_num_r >= sq_t;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      src_pkg::RT_IDLE: if (start) state_nxt = src_pkg::RT_DIV;
      src_pkg::RT_DIV:  if (cnt_r == 6'd0) state_nxt = src_pkg::RT_SQRT;
      src_pkg::RT_SQRT: if (bit_r[0]) state_nxt = src_pkg::RT_DONE;
      src_pkg::RT_DONE: state_nxt = src_pkg::RT_IDLE;
      default:          state_nxt = src_pkg::RT_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == src_pkg::RT_DONE);
    root = res_r[src_pkg::ROOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= src_pkg::RT_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      src_pkg::RT_IDLE: begin
        rem_r <= {1'b0, num};
        den_r <= den;
        quo_r <= '0;
        cnt_r <= 6'(src_pkg::QUO_W - 1);
      end
      src_pkg::RT_DIV: begin
        // remainder stays below the divisor, so one bit of headroom suffices
        rem_r <= {div_diff[src_pkg::PROD_W-1:0], 1'b0};
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          sq_num_r <= {1'b0, quo_nxt};
          res_r    <= '0;
          // start from the top power of four: the quotient is at most 2^60
          bit_r    <= {2'b01, {(src_pkg::SQ_W-2){1'b0}}};
        end
      end
      src_pkg::RT_SQRT: begin
        if (sq_ge) begin
          sq_num_r <= sq_num_r - sq_t;
          res_r    <= (res_r >> 1) + bit_r;
        end else begin
          res_r    <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/spearman_rank_correlation.sv]
// Spearman rank correlation with average ranks for ties, Q2.30 result.
//
// Pairs are taken one per cycle while loading; a pair is stored only when both
// values are valid. On the request marked last the block ranks and correlates:
// each kept pair k costs one pivot read, a scan of all n stored pairs through
// the two single-port stores and three passes of the shared 32 x 32 multiplier;
// the final part is two wide multiplies, a 61-step divider and a 31-step square
// root. in_ready is low from the last request until the result is registered;
// the result register holds while the next batch loads.
`timescale 1ns / 1ps

module spearman_rank_correlation #(
  parameter int MAX_PAIRS  = src_pkg::DEF_MAX_PAIRS,
  parameter int VALUE_BITS = src_pkg::DEF_VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  src_pkg::src_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output src_pkg::src_out_t out_data
);

  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int RW = CW + 2;

  src_pkg::src_state_t state_r, state_nxt;
  src_pkg::src_mop_t   mop_r;

  logic [VALUE_BITS-1:0] xmem [MAX_PAIRS];
  logic [VALUE_BITS-1:0] ymem [MAX_PAIRS];
  logic [VALUE_BITS-1:0] xrd_r, yrd_r, xpiv_r, ypiv_r;

  logic [CW-1:0] cnt_r, k_r, i_r;
  logic [CW-1:0] xbelow_r, xequal_r, ybelow_r, yequal_r;
  logic          ovf_r, hv_r, undef_r;

  logic signed [63:0] sxy_r, sxx_r, syy_r;
  logic [src_pkg::PROD_W-1:0] p_r;

  logic accept, keep, room, wr_en;
  logic [CW-1:0] n_fin;
  logic [AW-1:0] rd_addr;
  logic [63:0]   ext_x, ext_y;
  logic [VALUE_BITS-1:0] wx, wy;

  logic [RW-1:0]       rank_x, rank_y, mean;
  logic signed [RW:0]  dx, dy;
  logic [RW:0]         mag_x, mag_y;
  logic [63:0]         sxy_mag;

  logic                       mul_start, mul_done;
  logic [src_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [src_pkg::PROD_W-1:0] mul_prod;
  logic                       root_start, root_done;
  logic [src_pkg::ROOT_W-1:0] root_q;
  logic                       fin_ok;
  logic signed [31:0]         corr;

  src_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  src_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .num   (mul_prod),
    .den   (p_r),
    .done  (root_done),
    .root  (root_q)
  );

  always_comb begin
    accept = in_valid && in_ready;
    keep   = in_data.x_valid && in_data.y_valid;
    room   = cnt_r < CW'(MAX_PAIRS);
    wr_en  = accept && keep && room;
    n_fin  = cnt_r + CW'(wr_en);
    ext_x  = {32'b0, in_data.x_value};
    ext_y  = {32'b0, in_data.y_value};
    wx     = ext_x[VALUE_BITS-1:0];
    wy     = ext_y[VALUE_BITS-1:0];

    rank_x = RW'({xbelow_r, 1'b0}) + RW'(xequal_r) + RW'(1);
    rank_y = RW'({ybelow_r, 1'b0}) + RW'(yequal_r) + RW'(1);
    mean   = RW'(cnt_r) + RW'(1);
    dx     = $signed({1'b0, rank_x}) - $signed({1'b0, mean});
    dy     = $signed({1'b0, rank_y}) - $signed({1'b0, mean});
    mag_x  = dx[RW] ? (RW + 1)'(-dx) : dx;
    mag_y  = dy[RW] ? (RW + 1)'(-dy) : dy;
    sxy_mag = sxy_r[63] ? 64'(-sxy_r) : sxy_r;
    fin_ok = (mul_done && (mop_r == src_pkg::MOP_YY)) && (k_r + CW'(1) == cnt_r);
    corr   = sxy_r[63] ? -$signed({1'b0, root_q}) : $signed({1'b0, root_q});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      src_pkg::ST_LOAD:
        if (accept && in_data.last_sample) begin
          if (ovf_r || (keep && !room) || n_fin <= CW'(1)) state_nxt = src_pkg::ST_DONE;
          else state_nxt = src_pkg::ST_FETCH;
        end
      src_pkg::ST_FETCH: state_nxt = src_pkg::ST_PIVOT;
      src_pkg::ST_PIVOT: state_nxt = src_pkg::ST_SCAN;
      src_pkg::ST_SCAN:  if (i_r == cnt_r - CW'(1)) state_nxt = src_pkg::ST_FLUSH;
      src_pkg::ST_FLUSH: state_nxt = src_pkg::ST_MUL_GO;
      src_pkg::ST_MUL_GO: state_nxt = src_pkg::ST_MUL_WAIT;
      src_pkg::ST_MUL_WAIT:
        if (mul_done) begin
          case (mop_r)
            src_pkg::MOP_YY: state_nxt = fin_ok ? src_pkg::ST_CHECK : src_pkg::ST_FETCH;
            src_pkg::MOP_S:  state_nxt = src_pkg::ST_ROOT_GO;
            default:         state_nxt = src_pkg::ST_MUL_GO;
          endcase
        end
      src_pkg::ST_CHECK:
        state_nxt = (sxx_r == 64'sd0 || syy_r == 64'sd0) ? src_pkg::ST_DONE
                                                          : src_pkg::ST_MUL_GO;
      src_pkg::ST_ROOT_GO: state_nxt = src_pkg::ST_ROOT_WAIT;
      src_pkg::ST_ROOT_WAIT: if (root_done) state_nxt = src_pkg::ST_DONE;
      src_pkg::ST_DONE: if (!out_valid || out_ready) state_nxt = src_pkg::ST_LOAD;
      default: state_nxt = src_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == src_pkg::ST_LOAD);
    mul_start  = (state_r == src_pkg::ST_MUL_GO);
    root_start = (state_r == src_pkg::ST_ROOT_GO);
    rd_addr    = (state_r == src_pkg::ST_FETCH) ? k_r[AW-1:0] : i_r[AW-1:0];
    case (mop_r)
      src_pkg::MOP_XY: begin mul_a = 64'(mag_x); mul_b = 64'(mag_y); end
      src_pkg::MOP_XX: begin mul_a = 64'(mag_x); mul_b = 64'(mag_x); end
      src_pkg::MOP_YY: begin mul_a = 64'(mag_y); mul_b = 64'(mag_y); end
      src_pkg::MOP_P:  begin mul_a = sxx_r;      mul_b = syy_r;      end
      src_pkg::MOP_S:  begin mul_a = sxy_mag;    mul_b = sxy_mag;    end
      default:         begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xmem[cnt_r[AW-1:0]] <= wx;
      ymem[cnt_r[AW-1:0]] <= wy;
    end
    xrd_r <= xmem[rd_addr];
    yrd_r <= ymem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= src_pkg::ST_LOAD;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      hv_r      <= 1'b0;
      out_valid <= 1'b0;
      undef_r   <= 1'b0;
      mop_r     <= src_pkg::MOP_XY;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready && state_r != src_pkg::ST_DONE) out_valid <= 1'b0;
      hv_r <= (state_r == src_pkg::ST_SCAN);

      case (state_r)
        src_pkg::ST_LOAD: begin
          if (accept && keep) begin
            if (room) cnt_r <= n_fin;
            else      ovf_r <= 1'b1;
          end
          if (accept && in_data.last_sample) begin
            undef_r <= ovf_r || (keep && !room) || n_fin <= CW'(1);
            k_r     <= '0;
            sxy_r   <= '0;
            sxx_r   <= '0;
            syy_r   <= '0;
            mop_r   <= src_pkg::MOP_XY;
          end
        end
        src_pkg::ST_PIVOT: begin
          xpiv_r   <= xrd_r;
          ypiv_r   <= yrd_r;
          xbelow_r <= '0;
          xequal_r <= '0;
          ybelow_r <= '0;
          yequal_r <= '0;
          i_r      <= '0;
        end
        src_pkg::ST_SCAN: i_r <= i_r + CW'(1);
        src_pkg::ST_MUL_WAIT:
          if (mul_done) begin
            case (mop_r)
              src_pkg::MOP_XY: begin
                sxy_r <= (dx[RW] ^ dy[RW]) ? sxy_r - $signed(mul_prod[63:0])
                                           : sxy_r + $signed(mul_prod[63:0]);
                mop_r <= src_pkg::MOP_XX;
              end
              src_pkg::MOP_XX: begin
                sxx_r <= sxx_r + $signed(mul_prod[63:0]);
                mop_r <= src_pkg::MOP_YY;
              end
              src_pkg::MOP_YY: begin
                syy_r <= syy_r + $signed(mul_prod[63:0]);
                k_r   <= k_r + CW'(1);
                mop_r <= fin_ok ? src_pkg::MOP_P : src_pkg::MOP_XY;
              end
              src_pkg::MOP_P: begin
                p_r   <= mul_prod;
                mop_r <= src_pkg::MOP_S;
              end
              default: ;
            endcase
          end
        src_pkg::ST_CHECK:
          if (sxx_r == 64'sd0 || syy_r == 64'sd0) undef_r <= 1'b1;
        src_pkg::ST_DONE:
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.undefined   <= undef_r;
            out_data.correlation <= undef_r ? 32'sd0 : corr;
            out_data.pair_count  <= src_pkg::COUNT_W'(cnt_r);
            cnt_r                <= '0;
            ovf_r                <= 1'b0;
          end
        default: ;
      endcase

      // count the scanned entry against the pivot of both columns
      if (hv_r) begin
        if ($signed(xrd_r) < $signed(xpiv_r))  xbelow_r <= xbelow_r + CW'(1);
        else if (xrd_r == xpiv_r)              xequal_r <= xequal_r + CW'(1);
        if ($signed(yrd_r) < $signed(ypiv_r))  ybelow_r <= ybelow_r + CW'(1);
        else if (yrd_r == ypiv_r)              yequal_r <= yequal_r + CW'(1);
      end
    end
  end

endmodule
